// ===== src/rske_pkg.sv =====
// ----------------------------------------------------------------------------
// rske_pkg
// Shared types, constants and GF(2^8) helpers for the Reed-Solomon
// key-equation solver.
// ----------------------------------------------------------------------------
`default_nettype none

package rske_pkg;

    localparam int MAX_PARITY = 16;
    localparam int NCOEF      = MAX_PARITY + 1;
    localparam int DEG_W      = $clog2(NCOEF);
    localparam int LOAD_W     = $clog2(MAX_PARITY + 1);
    localparam int SYN_W      = $clog2(MAX_PARITY);

    // Configuration register indexes
    localparam logic CFG_PARITY = 1'b0;
    localparam logic CFG_POLY   = 1'b1;

    localparam logic [4:0] PARITY_RESET = 5'd16;
    localparam logic [8:0] POLY_RESET   = 9'h11D;

    localparam logic POLY_SIGMA = 1'b0;
    localparam logic POLY_OMEGA = 1'b1;

    typedef logic [7:0] gf_t;
    typedef gf_t poly_t [NCOEF];

    typedef struct packed {
        logic [7:0] syndrome_value;
        logic       syndrome_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] coef_value;
        logic [3:0] coef_index;
        logic       which_poly;
        logic       run_last;
    } out_word_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       init;
        logic       check_start;
        logic       inv_step;
        logic       inv_first;
        logic       div_start;
        logic       apply;
        logic       swap;
        logic       out_load;
        logic       out_poly;
        logic [3:0] out_idx;
        logic       out_last;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       rc_ge_half;
        logic       rem_ge_dr;
        logic [3:0] half;
    } stat_t;

    function automatic gf_t gf_mul(input gf_t a, input gf_t b, input logic [8:0] poly);
        logic [8:0] x;
        logic [8:0] red;
        gf_t        acc;
        red = poly | 9'h100;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
                acc = acc ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8])
                x = x ^ red;
        end
        return acc;
    endfunction

    function automatic logic [4:0] eff_parity(input logic [4:0] pc);
        logic [4:0] p;
        p = (pc > 5'(MAX_PARITY)) ? 5'(MAX_PARITY) : pc;
        p[0] = 1'b0;
        if (p < 5'd2)
            p = 5'd2;
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/rs_key_equation_euclid.sv =====
// ----------------------------------------------------------------------------
// rs_key_equation_euclid
// Reed-Solomon key-equation solver over GF(2^8), extended Euclidean form.
// ----------------------------------------------------------------------------
// Load: one syndrome word per cycle. Solve: an init state, then per iteration
// a check state, the inverse steps, a divide and an apply state per quotient
// term plus a swap, and a final check; then P+1 coefficient words, one per
// cycle when the sink is ready.
// The next block is loaded once the last coefficient is registered.
// Reset clears control, counters and configuration (P=16, poly 0x11D).
`default_nettype none

module rs_key_equation_euclid (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rske_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rske_pkg::out_word_t      out_word,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [8:0]          cfg_data
);
    import rske_pkg::*;

    cmd_t  cmd;
    stat_t st;

    rske_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_last   (in_word.syndrome_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    rske_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .st        (st),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ===== src/rske_ctrl.sv =====
// ----------------------------------------------------------------------------
// rske_ctrl
// Sequencer for syndrome load, Euclid iterations and coefficient output.
// ----------------------------------------------------------------------------
`default_nettype none

module rske_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_last,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rske_pkg::cmd_t     cmd,
    input  wire rske_pkg::stat_t st
);
    import rske_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_INIT, S_CHECK, S_INV, S_DIV, S_APPLY, S_OUT
    } state_t;

    state_t     state_reg;
    logic [2:0] cnt_reg;
    logic [3:0] idx_reg;
    logic       poly_reg;
    logic       out_valid_reg;
    logic       in_acc;
    logic       out_free;
    logic       out_end;

    assign in_ready  = (state_reg == S_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_end   = (poly_reg == POLY_OMEGA) && (idx_reg == st.half - 4'd1);

    // Decode commands
    always_comb
    begin
        cmd             = '0;
        cmd.out_poly    = poly_reg;
        cmd.out_idx     = idx_reg;
        cmd.out_last    = out_end;
        cmd.inv_first   = (cnt_reg == 3'd0);
        case (state_reg)
            S_LOAD:  cmd.load = in_acc;
            S_INIT:  cmd.init = 1'b1;
            S_CHECK: cmd.check_start = st.rc_ge_half;
            S_INV:   cmd.inv_step = 1'b1;
            S_DIV:
            begin
                cmd.div_start = st.rem_ge_dr;
                cmd.swap      = !st.rem_ge_dr;
            end
            S_APPLY: cmd.apply = 1'b1;
            S_OUT:   cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end

    // Hold state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            poly_reg      <= POLY_SIGMA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a new word, drop it once the word is taken
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                    if (in_acc && in_last)
                        state_reg <= S_INIT;
                S_INIT:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    cnt_reg <= '0;
                    if (st.rc_ge_half)
                        state_reg <= S_INV;
                    else
                    begin
                        idx_reg   <= '0;
                        poly_reg  <= POLY_SIGMA;
                        state_reg <= S_OUT;
                    end
                end
                S_INV:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                        state_reg <= S_DIV;
                end
                S_DIV:
                    state_reg <= st.rem_ge_dr ? S_APPLY : S_CHECK;
                S_APPLY:
                    state_reg <= S_DIV;
                S_OUT:
                    if (out_free)
                    begin
                        if (poly_reg == POLY_SIGMA && idx_reg == st.half)
                        begin
                            poly_reg <= POLY_OMEGA;
                            idx_reg  <= '0;
                        end
                        else if (out_end)
                            state_reg <= S_LOAD;
                        else
                            idx_reg <= idx_reg + 4'd1;
                    end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTH
    a_last_inits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_last) |=> (state_reg == S_INIT))
        else $error("last syndrome did not start the solve");
    a_inv_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INV && cnt_reg == 3'd7) |=> (state_reg == S_DIV))
        else $error("inverse did not finish after eight steps");
    a_apply_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> (state_reg == S_DIV))
        else $error("division step did not return");
    a_div_go: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && st.rem_ge_dr) |=> (state_reg == S_APPLY))
        else $error("division step skipped");
`endif

endmodule

`default_nettype wire

// ===== src/rske_dp.sv =====
// ----------------------------------------------------------------------------
// rske_dp
// Polynomial storage, GF(2^8) lanes, inverse unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rske_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire rske_pkg::in_word_t in_word,
    input  wire rske_pkg::cmd_t     cmd,
    output rske_pkg::stat_t         st,
    output rske_pkg::out_word_t     out_word
);
    import rske_pkg::*;

    logic [4:0]        parity_reg;
    logic [8:0]        poly_reg;
    logic [LOAD_W-1:0] load_cnt_reg;
    gf_t               syn_reg [MAX_PARITY];
    poly_t             rp_reg, rc_reg, lp_reg, lc_reg, rem_reg, tn_reg;
    gf_t               inv_base_reg, inv_res_reg, f_reg;
    logic [DEG_W-1:0]  sh_reg, dp_reg, dr_reg;
    out_word_t         out_reg;

    logic [4:0]        p_eff;
    logic [3:0]        half;
    logic [DEG_W-1:0]  rc_deg, rem_deg;
    logic              rc_nz, rem_nz;
    gf_t               f_next;
    poly_t             rem_upd, tn_upd;

    assign p_eff = eff_parity(parity_reg);
    assign half  = p_eff[4:1];

    // Find degrees of the current remainder and the running dividend
    always_comb
    begin
        rc_deg  = '0;
        rc_nz   = 1'b0;
        rem_deg = '0;
        rem_nz  = 1'b0;
        for (int k = 0; k < NCOEF; k++)
        begin
            if (rc_reg[k] != 8'd0)
            begin
                rc_deg = DEG_W'(k);
                rc_nz  = 1'b1;
            end
            if (rem_reg[k] != 8'd0)
            begin
                rem_deg = DEG_W'(k);
                rem_nz  = 1'b1;
            end
        end
    end

    assign st.half       = half;
    assign st.rc_ge_half = rc_nz && (rc_deg >= DEG_W'(half));
    assign st.rem_ge_dr  = rem_nz && (rem_deg >= dr_reg);

    assign f_next = gf_mul(rem_reg[rem_deg], inv_res_reg, poly_reg);

    // Subtract shifted multiples of divisor and locator
    always_comb
    begin
        logic [DEG_W-1:0] src;
        for (int k = 0; k < NCOEF; k++)
        begin
            src = DEG_W'(k) - sh_reg;
            if (DEG_W'(k) >= sh_reg)
            begin
                rem_upd[k] = rem_reg[k] ^ gf_mul(rc_reg[src], f_reg, poly_reg);
                tn_upd[k]  = tn_reg[k] ^ gf_mul(lc_reg[src], f_reg, poly_reg);
            end
            else
            begin
                rem_upd[k] = rem_reg[k];
                tn_upd[k]  = tn_reg[k];
            end
        end
        rem_upd[dp_reg] = 8'd0;
    end

    // Hold configuration and load count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg   <= PARITY_RESET;
            poly_reg     <= POLY_RESET;
            load_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_PARITY)
                parity_reg <= cfg_data[4:0];
            if (cfg_we && cfg_index == CFG_POLY)
                poly_reg <= cfg_data;
            if (cmd.init)
                load_cnt_reg <= '0;
            else if (cmd.load && load_cnt_reg < LOAD_W'(MAX_PARITY))
                load_cnt_reg <= load_cnt_reg + LOAD_W'(1);
        end
    end

    // Store syndromes, advance the working polynomials and load the output word
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_cnt_reg < LOAD_W'(MAX_PARITY))
            syn_reg[load_cnt_reg[SYN_W-1:0]] <= in_word.syndrome_value;
        if (cmd.init)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                rp_reg[k] <= (DEG_W'(k) == DEG_W'(p_eff)) ? 8'd1 : 8'd0;
                lp_reg[k] <= 8'd0;
                lc_reg[k] <= (k == 0) ? 8'd1 : 8'd0;
                if (k < MAX_PARITY && DEG_W'(k) < DEG_W'(p_eff))
                    rc_reg[k] <= syn_reg[SYN_W'(k)];
                else
                    rc_reg[k] <= 8'd0;
            end
        end
        if (cmd.check_start)
        begin
            dr_reg       <= rc_deg;
            inv_base_reg <= rc_reg[rc_deg];
            inv_res_reg  <= 8'd1;
            rem_reg      <= rp_reg;
            tn_reg       <= lp_reg;
        end
        if (cmd.inv_step)
        begin
            if (!cmd.inv_first)
                inv_res_reg <= gf_mul(inv_res_reg, inv_base_reg, poly_reg);
            inv_base_reg <= gf_mul(inv_base_reg, inv_base_reg, poly_reg);
        end
        if (cmd.div_start)
        begin
            f_reg  <= f_next;
            sh_reg <= rem_deg - dr_reg;
            dp_reg <= rem_deg;
        end
        if (cmd.apply)
        begin
            rem_reg <= rem_upd;
            tn_reg  <= tn_upd;
        end
        if (cmd.swap)
        begin
            rp_reg <= rc_reg;
            rc_reg <= rem_reg;
            lp_reg <= lc_reg;
            lc_reg <= tn_reg;
        end
        if (cmd.out_load)
        begin
            out_reg.coef_value <= (cmd.out_poly == POLY_SIGMA) ?
                                  lc_reg[{1'b0, cmd.out_idx}] : rc_reg[{1'b0, cmd.out_idx}];
            out_reg.coef_index <= cmd.out_idx;
            out_reg.which_poly <= cmd.out_poly;
            out_reg.run_last   <= cmd.out_last;
        end
    end

    assign out_word = out_reg;

endmodule

`default_nettype wire

// ===== test/rs_key_equation_euclid_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs_key_equation_euclid_tb
// Drives syndrome blocks into the key-equation solver under several parity
// and field-polynomial settings. Each finished block is solved in a local
// extended-Euclid model; the coefficient words that come out are compared
// in order against it, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module rs_key_equation_euclid_tb;
    import rske_pkg::*;

    localparam int TIMEOUT_CYCLES = 300000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 110;

    typedef struct {
        bit       is_cfg;
        bit       sel;      // register index for a write, last flag for a word
        bit [8:0] data;
        bit       zero_solve; // all-zero block: sigma = 1, omega = 0
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;
    logic      cfg_we;
    logic      cfg_index;
    logic [8:0] cfg_data;

    // local copy of the block state
    bit [7:0] syn_mem [MAX_PARITY];
    int       load_cnt;
    int       written_cnt;
    bit [4:0] parity_reg;
    bit [8:0] poly_reg;

    out_word_t coef_expect_q [$];
    out_word_t solve_words [$];

    int  mismatches;
    int  items_sent;
    int  words_checked;
    int  solves_done;
    longint cycle_cnt;
    bit  quiet;
    bit  hold_req;

    rs_key_equation_euclid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit [7:0] field_mul(bit [7:0] a, bit [7:0] b);
        bit [8:0] x;
        bit [8:0] red;
        bit [7:0] acc;
        red = poly_reg | 9'h100;
        x   = {1'b0, a};
        acc = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x[7:0];
            x = x << 1;
            if (x[8])
                x ^= red;
        end
        return acc;
    endfunction

    function automatic bit [7:0] field_inv(bit [7:0] a);
        bit [7:0] r;
        r = 8'd1;
        for (int i = 0; i < 254; i++)
            r = field_mul(r, a);
        return r;
    endfunction

    function automatic int poly_degree(bit [7:0] p [MAX_PARITY + 1]);
        for (int i = MAX_PARITY; i >= 0; i--)
            if (p[i] != 0)
                return i;
        return -1;
    endfunction

    function automatic int active_parity();
        int p;
        p = parity_reg;
        if (p > MAX_PARITY)
            p = MAX_PARITY;
        p = p & ~1;
        if (p < 2)
            p = 2;
        return p;
    endfunction

    // Store one syndrome word; on the last one run the Euclid solve and
    // fill solve_words with the coefficient words it yields.
    function automatic void solve_key_equation(in_word_t w);
        bit [7:0] r_prev [MAX_PARITY + 1];
        bit [7:0] r_cur [MAX_PARITY + 1];
        bit [7:0] t_prev [MAX_PARITY + 1];
        bit [7:0] t_cur [MAX_PARITY + 1];
        bit [7:0] rem [MAX_PARITY + 1];
        bit [7:0] quo [MAX_PARITY + 1];
        bit [7:0] t_new [MAX_PARITY + 1];
        int p;
        int half;
        int dr;
        int dp;
        bit [7:0] inv;
        bit [7:0] f;
        out_word_t o;
        solve_words.delete();
        if (load_cnt < MAX_PARITY)
        begin
            syn_mem[load_cnt] = w.syndrome_value;
            load_cnt++;
            if (load_cnt > written_cnt)
                written_cnt = load_cnt;
        end
        if (!w.syndrome_last)
            return;
        p    = active_parity();
        half = p / 2;
        for (int i = 0; i <= MAX_PARITY; i++)
        begin
            r_prev[i] = 0;
            r_cur[i]  = (i < p) ? syn_mem[i] : 8'd0;
            t_prev[i] = 0;
            t_cur[i]  = 0;
        end
        r_prev[p] = 1;
        t_cur[0]  = 1;
        while (poly_degree(r_cur) >= half)
        begin
            dr  = poly_degree(r_cur);
            inv = field_inv(r_cur[dr]);
            rem = r_prev;
            for (int i = 0; i <= MAX_PARITY; i++)
                quo[i] = 0;
            dp = poly_degree(rem);
            while (dp >= dr)
            begin
                f = field_mul(rem[dp], inv);
                quo[dp - dr] = f;
                for (int i = 0; i <= dr; i++)
                    rem[dp - dr + i] ^= field_mul(r_cur[i], f);
                rem[dp] = 0;
                dp = poly_degree(rem);
            end
            t_new = t_prev;
            for (int i = 0; i <= MAX_PARITY; i++)
                if (quo[i] != 0)
                    for (int j = 0; i + j <= MAX_PARITY; j++)
                        t_new[i + j] ^= field_mul(quo[i], t_cur[j]);
            r_prev = r_cur;
            r_cur  = rem;
            t_prev = t_cur;
            t_cur  = t_new;
        end
        for (int k = 0; k <= half; k++)
        begin
            o = '{coef_value: t_cur[k], coef_index: 4'(k), which_poly: POLY_SIGMA,
                  run_last: 1'b0};
            solve_words.push_back(o);
        end
        for (int k = 0; k < half; k++)
        begin
            o = '{coef_value: r_cur[k], coef_index: 4'(k), which_poly: POLY_OMEGA,
                  run_last: (k + 1 == half)};
            solve_words.push_back(o);
        end
        load_cnt = 0;
    endfunction

    // Offer one word and hold it until taken; predict at the accepting edge.
    task automatic send_syndrome(in_word_t w, bit zero_solve);
        bit taken;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
        solve_key_equation(w);
        if (w.syndrome_last)
            solves_done++;
        if (zero_solve)
        begin
            // all-zero syndromes leave sigma = 1 and omega = 0
            foreach (solve_words[k])
                solve_words[k].coef_value = (k == 0) ? 8'd1 : 8'd0;
        end
        foreach (solve_words[k])
            coef_expect_q.push_back(solve_words[k]);
    endtask

    // Write a register once the block has drained.
    task automatic write_register(bit idx, bit [8:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (coef_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PARITY)
            parity_reg = data[4:0];
        else
            poly_reg = data;
    endtask

    task automatic send_block(int len, bit all_zero);
        in_word_t w;
        for (int i = 0; i < len; i++)
        begin
            w.syndrome_value = all_zero ? 8'd0 : 8'($urandom_range(0, 255));
            w.syndrome_last  = (i == len - 1);
            send_syndrome(w, 1'b0);
        end
    endtask

    // Sink: random stalls, one long hold on request, none near the end.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Check each word on the cycle it is taken.
    always @(negedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (coef_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word %p", out_word);
            end
            else
            begin
                want = coef_expect_q.pop_front();
                words_checked++;
                if (out_word.coef_value !== want.coef_value
                    || out_word.coef_index !== want.coef_index
                    || out_word.which_poly !== want.which_poly
                    || out_word.run_last !== want.run_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word mismatch, expected %p got %p", want, out_word);
                end
            end
        end
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed [] = '{
            '{1'b1, CFG_PARITY, 9'd2,    1'b0},
            '{1'b0, 1'b0,       9'h00,   1'b0},
            '{1'b0, 1'b1,       9'h00,   1'b1},
            '{1'b0, 1'b0,       9'hFF,   1'b0},
            '{1'b0, 1'b1,       9'h80,   1'b0},
            '{1'b0, 1'b0,       9'h01,   1'b0},
            '{1'b0, 1'b1,       9'hFF,   1'b0},
            '{1'b0, 1'b1,       9'h7A,   1'b0},  // short block reuses entry 1
            '{1'b1, CFG_PARITY, 9'd3,    1'b0},  // odd count rounds down
            '{1'b0, 1'b0,       9'h12,   1'b0},
            '{1'b0, 1'b1,       9'h34,   1'b0},
            '{1'b1, CFG_PARITY, 9'd0,    1'b0},  // zero count raised to 2
            '{1'b0, 1'b0,       9'hAA,   1'b0},
            '{1'b0, 1'b1,       9'h01,   1'b0},
            '{1'b1, CFG_POLY,   9'h01D,  1'b0},  // top bit forced on
            '{1'b0, 1'b0,       9'h02,   1'b0},
            '{1'b0, 1'b1,       9'h03,   1'b0},
            '{1'b1, CFG_POLY,   9'h1FF,  1'b0},
            '{1'b0, 1'b0,       9'hFF,   1'b0},
            '{1'b0, 1'b1,       9'hFF,   1'b0},
            '{1'b1, CFG_POLY,   9'h100,  1'b0},
            '{1'b0, 1'b0,       9'h80,   1'b0},
            '{1'b0, 1'b1,       9'h80,   1'b0}
        };
        in_word_t w;
        int phase;
        int p;
        int len;
        int r;
        int rand_start;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_PARITY;
        cfg_data    = '0;
        mismatches  = 0;
        items_sent  = 0;
        words_checked = 0;
        solves_done = 0;
        cycle_cnt   = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        load_cnt    = 0;
        written_cnt = 0;
        parity_reg  = PARITY_RESET;
        poly_reg    = POLY_RESET;
        foreach (syn_mem[i])
            syn_mem[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_register(directed[i].sel, directed[i].data);
            else
            begin
                w.syndrome_value = directed[i].data[7:0];
                w.syndrome_last  = directed[i].sel;
                send_syndrome(w, directed[i].zero_solve);
            end
        end

        // Random phases: new settings, then a few blocks each.
        rand_start = items_sent;
        phase = 0;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin write_register(CFG_PARITY, 9'd16); write_register(CFG_POLY, 9'h11D); end
                1: begin write_register(CFG_PARITY, 9'd2);  write_register(CFG_POLY, 9'h1FF); end
                2: begin write_register(CFG_PARITY, 9'h1FF); write_register(CFG_POLY, 9'h000); end
                default:
                begin
                    write_register(CFG_PARITY, 9'($urandom_range(0, 511)));
                    write_register(CFG_POLY, ($urandom_range(0, 3) == 0)
                                   ? 9'($urandom_range(0, 511)) : 9'h11D);
                end
            endcase
            if (phase == 0)
                hold_req = 1'b1;
            p = active_parity();
            repeat ($urandom_range(2, 4))
            begin
                if (items_sent - rand_start >= RANDOM_ITEMS)
                    break;
                quiet = (items_sent - rand_start) > (RANDOM_ITEMS * 4 / 5);
                r = $urandom_range(0, 9);
                if (r == 0)
                    len = $urandom_range(p + 1, MAX_PARITY + 4);
                else if (r == 1 && written_cnt >= p && p > 2)
                    len = $urandom_range(1, p - 1);
                else
                    len = p;
                if (written_cnt + len < p)
                    len = p;
                send_block(len, $urandom_range(0, 7) == 0);
            end
            phase++;
        end

        // Drain and settle.
        in_valid <= 1'b0;
        while (coef_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d syndrome words in %0d solves over %0d random setting phases;",
                 items_sent, solves_done, phase);
        $display("checked %0d coefficient words, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0 && coef_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
